// ===== design/bsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, request and status codes and the controller state type
// of the bitmap slot allocator. No dependencies.
package bsa_pkg;

    // Default geometry of the occupancy bitmap.
    localparam int SLOT_COUNT_DEF = 1024;
    localparam int WORD_BITS_DEF  = 32;

    // Fixed widths of the beat fields.
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_LOOK,
        S_INVAL
    } ctrl_state_t;

endpackage

// ===== design/bitmap_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Bitmap slot allocator: one request at a time against an occupancy bitmap
// held in a synchronous single-read memory. Depends on bsa_pkg.
//
// Flow: an accepted request beat is decoded; a free or query then reads the
// bitmap word of its slot, an allocate scans the words from the first until
// it finds a clear bit or reaches the last one, and a rejected request goes
// straight to its result. A new request beat is taken once the last result
// is loaded into the result register, which may still wait for out_ready.
// The bitmap memory is read one word per cycle while an allocate scans.
// Reset: after rst_n rises, a clearing pass writes each of the WORD_COUNT
// bitmap words (32 by default) once, with only slot 0 marked; no request
// beat is taken until it finishes.
module bitmap_slot_allocator_unit #(
    parameter int SLOT_COUNT = bsa_pkg::SLOT_COUNT_DEF,
    parameter int WORD_BITS  = bsa_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bsa_pkg::KIND_W-1:0]    kind,
    input  logic [bsa_pkg::SLOT_W-1:0]    slot_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bsa_pkg::SLOT_W-1:0]    slot_out,
    output logic [bsa_pkg::STATUS_W-1:0]  status,
    output logic                          is_marked
);

    // Bitmap geometry. The last word may be only partly backed by slots;
    // its upper bits are masked out of every allocation search.
    localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int LAST_BITS  = SLOT_COUNT - (WORD_COUNT - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORD_COUNT - 1);

    // Slot range check is done at a width that holds both the slot field
    // and the slot count itself.
    localparam int CNT_BITS = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W    = (CNT_BITS > bsa_pkg::SLOT_W) ? CNT_BITS : bsa_pkg::SLOT_W;

    // The word index of a slot is slot / WORD_BITS, done as a multiply by a
    // rounded-up reciprocal. With a shift of twice the slot width the
    // rounding error stays below one for every 10-bit slot and every word
    // width in range, so the quotient is exact without a correction step.
    localparam int DIV_SH = 2 * bsa_pkg::SLOT_W;
    localparam int DIV_W  = bsa_pkg::SLOT_W + DIV_SH;
    localparam longint RECIP = ((64'd1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

    // Bitmap memory and its registered read port.
    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic                 mem_re;
    logic [WIDX_W-1:0]    mem_raddr;
    logic                 mem_we;
    logic [WIDX_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Control state.
    bsa_pkg::ctrl_state_t state_reg, state_next;
    logic [WIDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // Request being worked on and the scan position.
    logic [bsa_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [bsa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [WIDX_W-1:0]          word_idx_reg, word_idx_next;

    // Result register.
    logic [bsa_pkg::SLOT_W-1:0]   slot_out_reg, slot_out_next;
    logic [bsa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         marked_reg, marked_next;

    // Datapath helpers.
    logic [DIV_W-1:0]           div_prod;
    logic [WIDX_W-1:0]          word_of_slot;
    logic                       slot_ok;
    logic [bsa_pkg::SLOT_W-1:0] word_base;
    logic [BIT_W-1:0]           look_bit_idx;
    logic                       look_bit;
    logic [WORD_BITS-1:0]       free_bits;
    logic                       free_found;
    logic [BIT_W-1:0]           free_idx;
    logic                       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Free-or-query decode of the held slot number.
    assign slot_ok = (slot_reg != '0) &&
                     (CMP_W'(slot_reg) < CMP_W'(SLOT_COUNT));
    assign div_prod     = DIV_W'(slot_reg) * DIV_W'(RECIP);
    assign word_of_slot = WIDX_W'(div_prod >> DIV_SH);

    // Position of the slot inside the word that was read for it. The base
    // fits the slot width because it never exceeds the slot itself.
    assign word_base    = bsa_pkg::SLOT_W'(bsa_pkg::SLOT_W'(word_idx_reg) *
                                           bsa_pkg::SLOT_W'(WORD_BITS));
    assign look_bit_idx = BIT_W'(slot_reg - word_base);
    assign look_bit     = rd_data_reg[look_bit_idx];

    // Lowest clear bit of the word under scan.
    assign free_bits = ~rd_data_reg &
                       ((word_idx_reg == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}});

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                free_found = 1'b1;
                free_idx   = BIT_W'(b);
            end
        end
    end

    // Next state, memory control and result loading.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        word_idx_next  = word_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        slot_out_next  = slot_out_reg;
        status_next    = status_reg;
        marked_next    = marked_reg;
        in_ready       = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = word_idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = word_idx_reg;
        mem_wdata      = rd_data_reg;

        unique case (state_reg)
            bsa_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = (clr_cnt_reg == '0) ? WORD_BITS'(1) : '0;
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = bsa_pkg::S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + WIDX_W'(1);
                end
            end

            bsa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next  = kind;
                    slot_next  = slot_in;
                    state_next = bsa_pkg::S_DECODE;
                end
            end

            bsa_pkg::S_DECODE:
            begin
                if (kind_reg == bsa_pkg::KIND_ALLOC)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = '0;
                    word_idx_next = '0;
                    state_next    = bsa_pkg::S_SCAN;
                end
                else if ((kind_reg == bsa_pkg::KIND_FREE ||
                          kind_reg == bsa_pkg::KIND_QUERY) && slot_ok)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = word_of_slot;
                    word_idx_next = word_of_slot;
                    state_next    = bsa_pkg::S_LOOK;
                end
                else
                begin
                    state_next = bsa_pkg::S_INVAL;
                end
            end

            bsa_pkg::S_SCAN:
            begin
                if (free_found || word_idx_reg == LAST_WORD)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        marked_next    = 1'b0;
                        if (free_found)
                        begin
                            mem_we        = 1'b1;
                            mem_wdata     = rd_data_reg | (WORD_BITS'(1) << free_idx);
                            slot_out_next = word_base + bsa_pkg::SLOT_W'(free_idx);
                            status_next   = bsa_pkg::ST_OK;
                        end
                        else
                        begin
                            slot_out_next = '0;
                            status_next   = bsa_pkg::ST_FULL;
                        end
                        state_next = bsa_pkg::S_IDLE;
                    end
                    else
                    begin
                        // Result register still full: keep the word on the read port.
                        mem_re = 1'b1;
                    end
                end
                else
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = word_idx_reg + WIDX_W'(1);
                    word_idx_next = word_idx_reg + WIDX_W'(1);
                end
            end

            bsa_pkg::S_LOOK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_out_next  = '0;
                    status_next    = bsa_pkg::ST_OK;
                    marked_next    = 1'b0;
                    if (kind_reg == bsa_pkg::KIND_QUERY)
                    begin
                        marked_next = look_bit;
                    end
                    else if (look_bit)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_data_reg & ~(WORD_BITS'(1) << look_bit_idx);
                    end
                    else
                    begin
                        status_next = bsa_pkg::ST_INVALID;
                    end
                    state_next = bsa_pkg::S_IDLE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end

            bsa_pkg::S_INVAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_out_next  = '0;
                    status_next    = bsa_pkg::ST_INVALID;
                    marked_next    = 1'b0;
                    state_next     = bsa_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsa_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        slot_reg     <= slot_next;
        word_idx_reg <= word_idx_next;
        slot_out_reg <= slot_out_next;
        status_reg   <= status_next;
        marked_reg   <= marked_next;
    end

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign status    = status_reg;
    assign is_marked = marked_reg;

endmodule

// ===== design/bsa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the bitmap slot allocator and the bind that attaches
// them to the top level. Depends on bsa_pkg.
module bsa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bsa_pkg::SLOT_W-1:0]    slot_out,
    input logic [bsa_pkg::STATUS_W-1:0]  status,
    input logic                          is_marked
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot_out) &&
        $stable(status) && $stable(is_marked))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == bsa_pkg::ST_OK || status == bsa_pkg::ST_FULL ||
                       status == bsa_pkg::ST_INVALID))
        else $error("undefined status code");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bsa_pkg::ST_FULL |-> slot_out == '0 && !is_marked)
        else $error("full status with nonzero fields");

    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bsa_pkg::ST_INVALID |-> slot_out == '0 && !is_marked)
        else $error("invalid status with nonzero fields");

    a_marked_query: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_marked |-> status == bsa_pkg::ST_OK && slot_out == '0)
        else $error("marked answer on a non-query result");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_out  (slot_out),
    .status    (status),
    .is_marked (is_marked)
);
